### design/substring_first_match_finder_assert.svh
// ----------------------------------------------------------------------------
// Substring finder assertion macros
// Shorthand for clocked checks with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIRST_MATCH_FINDER_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_ASSERT_SVH

// consequent must hold in the same cycle
`define SFMF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the next cycle
`define SFMF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/sfmf_pkg.sv
// ----------------------------------------------------------------------------
// sfmf_pkg
// Constants, types and helpers shared by the substring finder modules.
// ----------------------------------------------------------------------------
package sfmf_pkg;

   localparam int unsigned PATTERN_MAX = 16;
   localparam int unsigned TEXT_MAX    = 65536;
   localparam int unsigned COUNT_W     = $clog2(TEXT_MAX + 1);
   localparam int unsigned LEN_W       = 5;
   localparam int unsigned POS_W       = 16;
   localparam int unsigned IDX_W       = 7;

   localparam logic [1:0] CSR_PATTERN_LO = 2'd0;
   localparam logic [1:0] CSR_PATTERN_HI = 2'd1;
   localparam logic [1:0] CSR_LENGTH     = 2'd2;
   localparam logic [1:0] CSR_START      = 2'd3;

   typedef struct packed {
      logic       care;
      logic [7:0] expected;
   } cell_cfg_type;

   // Pattern byte that window slot j must equal for a pattern of length len.
   function automatic cell_cfg_type cell_cfg(input logic [63:0]      lo,
                                             input logic [63:0]      hi,
                                             input logic [LEN_W-1:0] len,
                                             input int unsigned      j);
      logic [IDX_W-1:0] idx;
      cell_cfg_type     c;
      idx = {{(IDX_W-LEN_W){1'b0}}, len} - IDX_W'(1) - IDX_W'(j);
      c.care = (IDX_W'(j) < {{(IDX_W-LEN_W){1'b0}}, len});
      if (idx < IDX_W'(8)) begin
         c.expected = lo[{idx[2:0], 3'b000} +: 8];
      end else if (idx < IDX_W'(16)) begin
         c.expected = hi[{idx[2:0], 3'b000} +: 8];
      end else begin
         c.expected = 8'h00;
      end
      return c;
   endfunction

endpackage

### design/sfmf_cell.sv
// ----------------------------------------------------------------------------
// sfmf_cell
// One window slot: compares the byte arriving from its neighbor and holds it.
// ----------------------------------------------------------------------------
module sfmf_cell
   import sfmf_pkg::*;
(
   input  logic         clock,
   input  logic         shift,
   input  cell_cfg_type cfg,
   input  logic [7:0]   byte_in,
   output logic [7:0]   byte_out,
   output logic         hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;

   assign byte_in_next = shift ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   // slot ignored beyond the pattern length
   assign hit      = !cfg.care || (byte_in == cfg.expected);
   assign byte_out = byte_ff;

endmodule

### design/substring_first_match_finder.sv
// ----------------------------------------------------------------------------
// substring_first_match_finder
// Streams text bytes through a row of compare cells and reports the first
// occurrence of the pattern at or after the start index.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  req     | in        | text_byte, last
//  rsp     | out       | found, position (at most one per text)
//  csr     | in        | index, data (pattern lo/hi, length, start)
//
//  One byte per cycle while req_ready is high; all cells compare in the
//  cycle the byte is accepted, and the result register loads at that edge.
//  Reset clears the byte count, match flag, result valid and the pattern,
//  length and start registers, not found or position. req_ready drops
//  only while a result waits and rsp_ready is low. csr_ready is always high.
// ----------------------------------------------------------------------------
module substring_first_match_finder
   import sfmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_text_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [POS_W-1:0]  rsp_position,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

   logic [63:0]        pat_lo_ff, pat_lo_in;
   logic [63:0]        pat_hi_ff, pat_hi_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               reported_ff, reported_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;

   logic               req_fire;
   logic               csr_fire;
   logic [7:0]         chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] hits;
   logic [COUNT_W-1:0] end_count;
   logic [COUNT_W-1:0] match_start;
   logic               len_ok;
   logic               span_ok;
   logic               match;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // compare cells; the last slot's byte leaves the row
   assign chain[0] = req_text_byte;
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      sfmf_cell u_cell (
         .clock    (clock),
         .shift    (req_fire),
         .cfg      (cell_cfg(pat_lo_ff, pat_hi_ff, len_ff, j)),
         .byte_in  (chain[j]),
         .byte_out (chain[j+1]),
         .hit      (hits[j])
      );
   end

   // match qualification
   assign end_count   = count_ff + COUNT_W'(1);
   assign match_start = end_count - COUNT_W'(len_ff);
   assign len_ok      = (len_ff != '0) && (COUNT_W'(len_ff) <= COUNT_W'(PATTERN_MAX));
   assign span_ok     = (count_ff < COUNT_W'(TEXT_MAX)) &&
                        (end_count >= COUNT_W'(len_ff)) &&
                        (match_start >= COUNT_W'(start_ff));
   assign match       = !reported_ff && len_ok && span_ok && (&hits);

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_PATTERN_LO: pat_lo_in = csr_data;
            CSR_PATTERN_HI: pat_hi_in = csr_data;
            CSR_LENGTH:     len_in    = csr_data[LEN_W-1:0];
            CSR_START:      start_in  = csr_data[POS_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      count_in        = count_ff;
      reported_in     = reported_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (req_fire) begin
         if (match) begin
            rsp_valid_in    = 1'b1;
            rsp_found_in    = 1'b1;
            rsp_position_in = match_start[POS_W-1:0];
         end else if (req_last && !reported_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_found_in    = 1'b0;
            rsp_position_in = '0;
         end
         if (req_last) begin
            count_in    = '0;
            reported_in = 1'b0;
         end else begin
            reported_in = reported_ff || match;
            // hold the count once it saturates
            if (count_ff < COUNT_W'(TEXT_MAX)) begin
               count_in = end_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         len_ff       <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         len_ff       <= len_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

`include "substring_first_match_finder_assert.svh"

   `SFMF_ASSERT_NEXT(a_last_clears, req_fire && req_last, (count_ff == '0) && !reported_ff, "text state not cleared after last byte")
   `SFMF_ASSERT_NEXT(a_match_emits, req_fire && match, rsp_valid_ff && rsp_found_ff, "match did not produce a found word")
   `SFMF_ASSERT_NOW(a_miss_zero_pos, rsp_valid_ff && !rsp_found_ff, rsp_position_ff == '0, "not-found word carries a position")

endmodule
